// ===== rtl/core/cvcc_pkg.sv =====
package cvcc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned GAIN_W   = 13;
  localparam int unsigned LIM_W    = 23;
  localparam int unsigned IMEAS_W  = 22;
  localparam int unsigned UMEAS_W  = 29;
  localparam int unsigned VT10_W   = 17;
  localparam int unsigned MUL_A_W  = 13;
  localparam int unsigned MUL_B_W  = 17;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned CMP_W    = 30;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1023;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 13'd4096;

  // 782336 = 191 * 4096, so the divide starts from a remainder of 191
  localparam logic [15:0]        LIGHT_NUM_HI = 16'd191;
  localparam logic [3:0]         DIV_STEPS    = 4'd12;
  localparam logic [MUL_B_W-1:0] VOLT_COEF    = 17'd127479;
  localparam logic [MUL_B_W-1:0] CURR_COEF    = 17'd627;
  localparam logic [MUL_B_W-1:0] VOLT_TEN     = 17'd10;
  // 10 mA band on the mA*4096 scale
  localparam logic [24:0]        CURR_BAND    = 25'd40960;
  // 100 mV band on the mV*10*4096 scale
  localparam logic [CMP_W-1:0]   VOLT_BAND    = 30'd4096000;

  // gain source codes
  localparam logic [2:0] GM_FIXED  = 3'd0;
  localparam logic [2:0] GM_PHOTO  = 3'd1;
  localparam logic [2:0] GM_CELL   = 3'd2;
  localparam logic [2:0] GM_SENSOR = 3'd3;
  localparam logic [2:0] GM_ORBIT  = 3'd4;

  // light sensor status codes
  localparam logic [1:0] LS_OK        = 2'd0;
  localparam logic [1:0] LS_ADDR_FAIL = 2'd1;

  // register indexes
  localparam logic [2:0] REG_GAIN_MODE   = 3'd0;
  localparam logic [2:0] REG_VOLT_TARGET = 3'd1;
  localparam logic [2:0] REG_CURR_TARGET = 3'd2;
  localparam logic [2:0] REG_DUTY_INC    = 3'd3;
  localparam logic [2:0] REG_ORBIT_PER   = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_GAIN,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_LIM,
    OP_MUL_I,
    OP_MUL_U,
    OP_MUL_V,
    OP_DECIDE,
    OP_COMMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_IN_WAIT,
    C_NO_DIV,
    C_DIV_LOOP,
    C_OUT_BUSY,
    C_ALWAYS
  } cond_e;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucw_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]  gain_mode;
    logic [12:0] volt_target;
    logic [10:0] curr_target;
    logic [9:0]  duty_inc;
    logic [15:0] orbit_period;
  } cfg_t;

  typedef struct packed {
    logic gain_one;
    logic orbit_clr;
  } cfg_evt_t;

  // control store: jump to target when the condition holds, else fall through
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    unique case (s)
      4'd0:    w = '{op: OP_ACCEPT,   cond: C_IN_WAIT,  target: 4'd0};
      4'd1:    w = '{op: OP_GAIN,     cond: C_NO_DIV,   target: 4'd4};
      4'd2:    w = '{op: OP_DIV_STEP, cond: C_DIV_LOOP, target: 4'd2};
      4'd3:    w = '{op: OP_DIV_END,  cond: C_NEXT,     target: 4'd0};
      4'd4:    w = '{op: OP_MUL_LIM,  cond: C_NEXT,     target: 4'd0};
      4'd5:    w = '{op: OP_MUL_I,    cond: C_NEXT,     target: 4'd0};
      4'd6:    w = '{op: OP_MUL_U,    cond: C_NEXT,     target: 4'd0};
      4'd7:    w = '{op: OP_MUL_V,    cond: C_NEXT,     target: 4'd0};
      4'd8:    w = '{op: OP_DECIDE,   cond: C_NEXT,     target: 4'd0};
      4'd9:    w = '{op: OP_COMMIT,   cond: C_OUT_BUSY, target: 4'd9};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: 4'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/cv_cc_pwm_step_regulator.sv =====
// channel   direction  handshake              payload
// in        sink       in_valid_i/in_stall_o  volt, curr, photo, cell samples, light word,
//                                             light status, second tick
// out       source     out_valid_o/out_stall_i pwm duty, current mode flag, limit, gain,
//                                             orbit toggle flag
// cfg       apb slave  psel/penable/pwrite    five control registers at 4*index
//
// after an accept the sequencer runs the gain step, then the 12-step restoring divide when
// the light sensor gain needs it, then the limit, current, voltage and setpoint products,
// decide and commit; the result beat is offered from the output register after commit
// one item is in flight at a time; a finished result sits in the output
// register while the next item is taken and worked on
// a stalled output holds the sequencer on its commit step
// reset: duty 1023, gain one, orbit count zero, registers at their defaults
module cv_cc_pwm_step_regulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [11:0]        volt_sample_i,
  input  logic [11:0]        curr_sample_i,
  input  logic [11:0]        photo_sample_i,
  input  logic [11:0]        cell_sample_i,
  input  logic signed [15:0] light_reading_i,
  input  logic [1:0]         light_status_i,
  input  logic               second_tick_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         pwm_duty_o,
  output logic               current_mode_active_o,
  output logic [10:0]        limit_ma_o,
  output logic [12:0]        gain_q12_o,
  output logic               orbit_toggled_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cvcc_pkg::cfg_t       cfg;
  cvcc_pkg::cfg_evt_t   cfg_evt;
  cvcc_pkg::op_e        op;
  cvcc_pkg::dp_status_t dp_status;

  // register file, also flags mode writes that reset the gain
  cvcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .evt_o   (cfg_evt)
  );

  // step counter walking the control store
  cvcc_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (dp_status),
    .op_o       (op),
    .in_stall_o (in_stall_o)
  );

  // gain source, divider, shared multiplier, band compares, duty and output beat
  cvcc_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .op_i                  (op),
    .cfg_i                 (cfg),
    .evt_i                 (cfg_evt),
    .in_valid_i            (in_valid_i),
    .volt_sample_i         (volt_sample_i),
    .curr_sample_i         (curr_sample_i),
    .photo_sample_i        (photo_sample_i),
    .cell_sample_i         (cell_sample_i),
    .light_reading_i       (light_reading_i),
    .light_status_i        (light_status_i),
    .second_tick_i         (second_tick_i),
    .out_stall_i           (out_stall_i),
    .status_o              (dp_status),
    .out_valid_o           (out_valid_o),
    .pwm_duty_o            (pwm_duty_o),
    .current_mode_active_o (current_mode_active_o),
    .limit_ma_o            (limit_ma_o),
    .gain_q12_o            (gain_q12_o),
    .orbit_toggled_o       (orbit_toggled_o)
  );

endmodule

// ===== rtl/core/cvcc_regs.sv =====
module cvcc_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cvcc_pkg::cfg_t        cfg_o,
  output cvcc_pkg::cfg_evt_t    evt_o
);

  cvcc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        cvcc_pkg::REG_GAIN_MODE:   cfg_d.gain_mode    = pwdata[2:0];
        cvcc_pkg::REG_VOLT_TARGET: cfg_d.volt_target  = pwdata[12:0];
        cvcc_pkg::REG_CURR_TARGET: cfg_d.curr_target  = pwdata[10:0];
        cvcc_pkg::REG_DUTY_INC:    cfg_d.duty_inc     = pwdata[9:0];
        cvcc_pkg::REG_ORBIT_PER:   cfg_d.orbit_period = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_mode    <= cvcc_pkg::GM_PHOTO;
      cfg_q.volt_target  <= 13'd5500;
      cfg_q.curr_target  <= 11'd250;
      cfg_q.duty_inc     <= 10'd10;
      cfg_q.orbit_period <= 16'd899;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // mode writes that reset the gain state
  always_comb begin
    evt_o.gain_one  = wr_en && (idx == cvcc_pkg::REG_GAIN_MODE) &&
                      ((pwdata[2:0] == cvcc_pkg::GM_ORBIT) ||
                       (pwdata[2:0] == cvcc_pkg::GM_FIXED));
    evt_o.orbit_clr = wr_en && (idx == cvcc_pkg::REG_GAIN_MODE) &&
                      (pwdata[2:0] == cvcc_pkg::GM_ORBIT);
  end

  always_comb begin
    unique case (idx)
      cvcc_pkg::REG_GAIN_MODE:   prdata = {29'd0, cfg_q.gain_mode};
      cvcc_pkg::REG_VOLT_TARGET: prdata = {19'd0, cfg_q.volt_target};
      cvcc_pkg::REG_CURR_TARGET: prdata = {21'd0, cfg_q.curr_target};
      cvcc_pkg::REG_DUTY_INC:    prdata = {22'd0, cfg_q.duty_inc};
      cvcc_pkg::REG_ORBIT_PER:   prdata = {16'd0, cfg_q.orbit_period};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/cvcc_useq.sv =====
module cvcc_useq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  cvcc_pkg::dp_status_t   status_i,
  output cvcc_pkg::op_e          op_o,
  output logic                   in_stall_o
);

  cvcc_pkg::step_t step_q, step_d;
  cvcc_pkg::ucw_t  ucw;
  logic            jump;

  assign ucw = cvcc_pkg::ucode(step_q);

  always_comb begin
    unique case (ucw.cond)
      cvcc_pkg::C_NEXT:     jump = 1'b0;
      cvcc_pkg::C_IN_WAIT:  jump = !in_valid_i;
      cvcc_pkg::C_NO_DIV:   jump = !status_i.div_needed;
      cvcc_pkg::C_DIV_LOOP: jump = !status_i.div_last;
      cvcc_pkg::C_OUT_BUSY: jump = status_i.out_busy;
      cvcc_pkg::C_ALWAYS:   jump = 1'b1;
      default:              jump = 1'b1;
    endcase
  end

  assign step_d = jump ? ucw.target : step_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o       = ucw.op;
  assign in_stall_o = (ucw.op != cvcc_pkg::OP_ACCEPT);

endmodule

// ===== rtl/core/cvcc_datapath.sv =====
module cvcc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cvcc_pkg::op_e         op_i,
  input  cvcc_pkg::cfg_t        cfg_i,
  input  cvcc_pkg::cfg_evt_t    evt_i,
  input  logic                  in_valid_i,
  input  logic [11:0]           volt_sample_i,
  input  logic [11:0]           curr_sample_i,
  input  logic [11:0]           photo_sample_i,
  input  logic [11:0]           cell_sample_i,
  input  logic signed [15:0]    light_reading_i,
  input  logic [1:0]            light_status_i,
  input  logic                  second_tick_i,
  input  logic                  out_stall_i,
  output cvcc_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  output logic [9:0]            pwm_duty_o,
  output logic                  current_mode_active_o,
  output logic [10:0]           limit_ma_o,
  output logic [12:0]           gain_q12_o,
  output logic                  orbit_toggled_o
);

  // latched item
  logic [11:0]        volt_q, curr_q, photo_q, cell_q;
  logic signed [15:0] reading_q;
  logic [1:0]         lstat_q;
  logic               tick_q;

  // state
  logic [cvcc_pkg::DUTY_W-1:0] duty_q, duty_d;
  logic [cvcc_pkg::GAIN_W-1:0] gain_q, gain_d;
  logic [15:0]                 orbit_q, orbit_d;
  logic                        toggled_q, toggled_d;

  // divider
  logic [15:0] rem_q, rem_d;
  logic [11:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [16:0] rem_sh;
  logic        rem_ge;

  // products and decision
  logic [cvcc_pkg::MUL_A_W-1:0] mul_a;
  logic [cvcc_pkg::MUL_B_W-1:0] mul_b;
  logic [cvcc_pkg::MUL_P_W-1:0] prod;
  logic [cvcc_pkg::LIM_W-1:0]   lim_q;
  logic [cvcc_pkg::IMEAS_W-1:0] imeas_q;
  logic [cvcc_pkg::UMEAS_W-1:0] umeas_q;
  logic [cvcc_pkg::VT10_W-1:0]  vt10_q;
  logic                         cur_q, dn_q, up_q;
  logic                         cur_c, i_dn, i_up, v_dn, v_up;
  logic [24:0]                  imeas_x, lim_x;
  logic [cvcc_pkg::CMP_W-1:0]   umeas_x, vset_x;

  // gain resolution
  logic [16:0] cell20;
  logic [15:0] orbit_sum;
  logic        div_needed;

  logic [10:0] duty_sum;
  logic [9:0]  duty_nx;
  logic        out_valid_q;
  logic        out_busy;
  logic        commit;

  logic [9:0]  pwm_q;
  logic        curm_q;
  logic [10:0] limo_q;
  logic [12:0] gaino_q;
  logic        togo_q;

  assign out_busy = out_valid_q & out_stall_i;
  assign commit   = (op_i == cvcc_pkg::OP_COMMIT) && !out_busy;

  assign div_needed = (cfg_i.gain_mode == cvcc_pkg::GM_SENSOR) &&
                      (lstat_q == cvcc_pkg::LS_OK) && !reading_q[15] &&
                      (reading_q[14:0] > cvcc_pkg::LIGHT_NUM_HI[14:0]);

  assign status_o.div_needed = div_needed;
  assign status_o.div_last   = (cnt_q == 4'd1);
  assign status_o.out_busy   = out_busy;

  // item capture
  always_ff @(posedge clk_i) begin
    if ((op_i == cvcc_pkg::OP_ACCEPT) && in_valid_i) begin
      volt_q    <= volt_sample_i;
      curr_q    <= curr_sample_i;
      photo_q   <= photo_sample_i;
      cell_q    <= cell_sample_i;
      reading_q <= light_reading_i;
      lstat_q   <= light_status_i;
      tick_q    <= second_tick_i;
    end
  end

  assign cell20    = {1'b0, cell_q, 4'b0} + {3'b0, cell_q, 2'b0};
  assign orbit_sum = orbit_q + {15'd0, tick_q};
  assign rem_sh    = {rem_q, 1'b0};
  assign rem_ge    = rem_sh >= {2'b0, reading_q[14:0]};

  // gain, orbit and divider updates
  always_comb begin
    gain_d    = gain_q;
    orbit_d   = orbit_q;
    toggled_d = toggled_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    unique case (op_i)
      cvcc_pkg::OP_GAIN: begin
        toggled_d = 1'b0;
        rem_d     = cvcc_pkg::LIGHT_NUM_HI;
        quo_d     = '0;
        cnt_d     = cvcc_pkg::DIV_STEPS;
        unique case (cfg_i.gain_mode)
          cvcc_pkg::GM_PHOTO: gain_d = {1'b0, photo_q};
          cvcc_pkg::GM_CELL: begin
            gain_d = (cell20 > {4'd0, cvcc_pkg::GAIN_ONE}) ? cvcc_pkg::GAIN_ONE
                                                           : cell20[12:0];
          end
          cvcc_pkg::GM_SENSOR: begin
            if (lstat_q == cvcc_pkg::LS_OK) begin
              if (reading_q[15]) begin
                gain_d = '0;
              end else if (!div_needed) begin
                // zero or small reading saturates at one
                gain_d = cvcc_pkg::GAIN_ONE;
              end
            end else if (lstat_q != cvcc_pkg::LS_ADDR_FAIL) begin
              gain_d = cvcc_pkg::GAIN_ONE;
            end
          end
          cvcc_pkg::GM_ORBIT: begin
            orbit_d = orbit_sum;
            if (orbit_sum >= cfg_i.orbit_period) begin
              orbit_d   = '0;
              gain_d    = cvcc_pkg::GAIN_ONE - gain_q;
              toggled_d = 1'b1;
            end
          end
          default: gain_d = cvcc_pkg::GAIN_ONE;
        endcase
      end
      cvcc_pkg::OP_DIV_STEP: begin
        rem_d = rem_ge ? rem_sh[15:0] - {1'b0, reading_q[14:0]} : rem_sh[15:0];
        quo_d = {quo_q[10:0], rem_ge};
        cnt_d = cnt_q - 4'd1;
      end
      cvcc_pkg::OP_DIV_END: gain_d = {1'b0, quo_q};
      default: ;
    endcase
    if (evt_i.gain_one) begin
      gain_d = cvcc_pkg::GAIN_ONE;
    end
    if (evt_i.orbit_clr) begin
      orbit_d = '0;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    unique case (op_i)
      cvcc_pkg::OP_MUL_LIM: begin
        mul_a = {2'b0, cfg_i.curr_target};
        mul_b = {4'b0, gain_q};
      end
      cvcc_pkg::OP_MUL_I: begin
        mul_a = {1'b0, curr_q};
        mul_b = cvcc_pkg::CURR_COEF;
      end
      cvcc_pkg::OP_MUL_U: begin
        mul_a = {1'b0, volt_q};
        mul_b = cvcc_pkg::VOLT_COEF;
      end
      cvcc_pkg::OP_MUL_V: begin
        mul_a = cfg_i.volt_target;
        mul_b = cvcc_pkg::VOLT_TEN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      cvcc_pkg::OP_MUL_LIM: lim_q   <= prod[cvcc_pkg::LIM_W-1:0];
      cvcc_pkg::OP_MUL_I:   imeas_q <= prod[cvcc_pkg::IMEAS_W-1:0];
      cvcc_pkg::OP_MUL_U:   umeas_q <= prod[cvcc_pkg::UMEAS_W-1:0];
      cvcc_pkg::OP_MUL_V:   vt10_q  <= prod[cvcc_pkg::VT10_W-1:0];
      default: ;
    endcase
  end

  // band compares, all on unsigned scales
  assign imeas_x = {3'b0, imeas_q};
  assign lim_x   = {2'b0, lim_q};
  assign umeas_x = {1'b0, umeas_q};
  assign vset_x  = {1'b0, vt10_q, 12'b0};
  assign cur_c   = imeas_x > lim_x;
  assign i_dn    = (imeas_x + cvcc_pkg::CURR_BAND) < lim_x;
  assign i_up    = imeas_x > (lim_x + cvcc_pkg::CURR_BAND);
  assign v_dn    = (umeas_x + cvcc_pkg::VOLT_BAND) < vset_x;
  assign v_up    = umeas_x > (vset_x + cvcc_pkg::VOLT_BAND);

  always_ff @(posedge clk_i) begin
    if (op_i == cvcc_pkg::OP_DECIDE) begin
      cur_q <= cur_c;
      dn_q  <= cur_c ? i_dn : v_dn;
      up_q  <= cur_c ? i_up : v_up;
    end
  end

  // saturating duty step
  assign duty_sum = {1'b0, duty_q} + {1'b0, cfg_i.duty_inc};

  always_comb begin
    duty_nx = duty_q;
    if (dn_q) begin
      duty_nx = (duty_q > cfg_i.duty_inc) ? duty_q - cfg_i.duty_inc : '0;
    end else if (up_q && (duty_q < cvcc_pkg::DUTY_MAX)) begin
      duty_nx = (duty_sum > {1'b0, cvcc_pkg::DUTY_MAX}) ? cvcc_pkg::DUTY_MAX
                                                        : duty_sum[9:0];
    end
  end

  assign duty_d = commit ? duty_nx : duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q      <= cvcc_pkg::DUTY_MAX;
      gain_q      <= cvcc_pkg::GAIN_ONE;
      orbit_q     <= '0;
      toggled_q   <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      duty_q    <= duty_d;
      gain_q    <= gain_d;
      orbit_q   <= orbit_d;
      toggled_q <= toggled_d;
      rem_q     <= rem_d;
      quo_q     <= quo_d;
      cnt_q     <= cnt_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      pwm_q   <= duty_nx;
      curm_q  <= cur_q;
      limo_q  <= lim_q[22:12];
      gaino_q <= gain_q;
      togo_q  <= toggled_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign pwm_duty_o            = pwm_q;
  assign current_mode_active_o = curm_q;
  assign limit_ma_o            = limo_q;
  assign gain_q12_o            = gaino_q;
  assign orbit_toggled_o       = togo_q;

endmodule

// ===== bench/tb_cv_cc_pwm_step_regulator.sv =====
module tb_cv_cc_pwm_step_regulator;
  timeunit 1ns;
  timeprecision 1ps;

  // run limits: the worst item adds the divide loop, an output stall and a source gap to its work
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_CYCLES  = 30;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_PASSES  = 125;

  // gain source codes with no name in the package, all behave as fixed gain one
  localparam logic [2:0] GM_SPARE_LO = 3'd5;
  localparam logic [2:0] GM_SPARE_MID = 3'd6;
  localparam logic [2:0] GM_SPARE_HI = 3'd7;
  // sensor status codes beyond the named ones, both force gain one
  localparam logic [1:0] LS_READ_FAIL = 2'd2;
  localparam logic [1:0] LS_RESERVED  = 2'd3;

  // one control pass as sent, plus a flag that holds it back until the block drains
  typedef struct packed {
    logic [11:0] volt;
    logic [11:0] curr;
    logic [11:0] photo;
    logic [11:0] solar;
    logic [15:0] reading;
    logic [1:0]  status;
    logic        tick;
    logic        hold;
  } pass_in_t;

  // what one pass produces
  typedef struct packed {
    logic [9:0]  duty;
    logic        cur_mode;
    logic [10:0] limit;
    logic [12:0] gain;
    logic        toggled;
  } ctrl_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [11:0]        volt_sample_i   = '0;
  logic [11:0]        curr_sample_i   = '0;
  logic [11:0]        photo_sample_i  = '0;
  logic [11:0]        cell_sample_i   = '0;
  logic signed [15:0] light_reading_i = '0;
  logic [1:0]         light_status_i  = '0;
  logic               second_tick_i   = 1'b0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  pwm_duty_o;
  logic        current_mode_active_o;
  logic [10:0] limit_ma_o;
  logic [12:0] gain_q12_o;
  logic        orbit_toggled_o;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  cv_cc_pwm_step_regulator uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .volt_sample_i         (volt_sample_i),
    .curr_sample_i         (curr_sample_i),
    .photo_sample_i        (photo_sample_i),
    .cell_sample_i         (cell_sample_i),
    .light_reading_i       (light_reading_i),
    .light_status_i        (light_status_i),
    .second_tick_i         (second_tick_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .pwm_duty_o            (pwm_duty_o),
    .current_mode_active_o (current_mode_active_o),
    .limit_ma_o            (limit_ma_o),
    .gain_q12_o            (gain_q12_o),
    .orbit_toggled_o       (orbit_toggled_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // regulator image: register copy and the three state words, all at reset values
  logic [2:0]  cfg_mode    = cvcc_pkg::GM_PHOTO;
  logic [12:0] cfg_volt_mv = 13'd5500;
  logic [10:0] cfg_curr_ma = 11'd250;
  logic [9:0]  cfg_step    = 10'd10;
  logic [15:0] cfg_period  = 16'd899;
  logic [9:0]  duty_lvl    = cvcc_pkg::DUTY_MAX;
  logic [12:0] gain_lvl    = cvcc_pkg::GAIN_ONE;
  logic [15:0] orbit_cnt   = '0;

  pass_in_t  sample_q[$];       // passes waiting to be sent
  ctrl_res_t ctrl_result_q[$];  // control results owed by the block, oldest first

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;

  // idling switches, flipped per phase
  bit src_idle  = 1'b0;
  bit sink_idle = 1'b0;

  function automatic logic [12:0] cap_gain(longint g);
    return (g > longint'(cvcc_pkg::GAIN_ONE)) ? cvcc_pkg::GAIN_ONE : 13'(g);
  endfunction

  // no decrease once at zero, floor at zero otherwise
  function automatic logic [9:0] duty_lower(logic [9:0] d);
    if (d == '0) return d;
    return (d > cfg_step) ? d - cfg_step : '0;
  endfunction

  // no increase once at the top, saturate at the top otherwise
  function automatic logic [9:0] duty_raise(logic [9:0] d);
    int s;
    if (d >= cvcc_pkg::DUTY_MAX) return d;
    s = int'(d) + int'(cfg_step);
    return (s > int'(cvcc_pkg::DUTY_MAX)) ? cvcc_pkg::DUTY_MAX : 10'(s);
  endfunction

  // one control pass: gain update, limit scaling, cv/cc choice and duty step
  function automatic ctrl_res_t regulate_pass(pass_in_t p);
    ctrl_res_t r;
    longint    lim, imeas, umeas, vt_scaled, lo_edge, hi_edge;
    int        rd;
    logic      cur;
    rd        = int'($signed(p.reading));
    r.toggled = 1'b0;
    case (cfg_mode)
      cvcc_pkg::GM_PHOTO: gain_lvl = cap_gain(longint'(p.photo));
      cvcc_pkg::GM_CELL:  gain_lvl = cap_gain(longint'(p.solar) * 20);
      cvcc_pkg::GM_SENSOR: begin
        if (p.status == cvcc_pkg::LS_OK) begin
          if (rd == 0) gain_lvl = cvcc_pkg::GAIN_ONE;
          else if (rd < 0) gain_lvl = '0;
          else gain_lvl = cap_gain(longint'((int'(cvcc_pkg::LIGHT_NUM_HI) * 4096) / rd));
        end else if (p.status != cvcc_pkg::LS_ADDR_FAIL) begin
          gain_lvl = cvcc_pkg::GAIN_ONE;
        end
      end
      cvcc_pkg::GM_ORBIT: begin
        orbit_cnt = orbit_cnt + 16'(p.tick);
        if (orbit_cnt >= cfg_period) begin
          orbit_cnt = '0;
          gain_lvl  = cvcc_pkg::GAIN_ONE - cap_gain(longint'(gain_lvl));
          r.toggled = 1'b1;
        end
      end
      default: gain_lvl = cvcc_pkg::GAIN_ONE;
    endcase

    // current on the mA*4096 scale, voltage on the mV*10*4096 scale
    lim       = longint'(cfg_curr_ma) * longint'(gain_lvl);
    imeas     = longint'(p.curr) * longint'(cvcc_pkg::CURR_COEF);
    umeas     = longint'(p.volt) * longint'(cvcc_pkg::VOLT_COEF);
    vt_scaled = longint'(cfg_volt_mv) * longint'(cvcc_pkg::VOLT_TEN) * 4096;
    lo_edge   = vt_scaled - longint'(cvcc_pkg::VOLT_BAND);
    hi_edge   = vt_scaled + longint'(cvcc_pkg::VOLT_BAND);

    cur = !(lim >= imeas);
    if (!cur) begin
      if (umeas < lo_edge) duty_lvl = duty_lower(duty_lvl);
      else if (umeas > hi_edge) duty_lvl = duty_raise(duty_lvl);
    end else begin
      if (imeas < lim - longint'(cvcc_pkg::CURR_BAND)) duty_lvl = duty_lower(duty_lvl);
      else if (imeas > lim + longint'(cvcc_pkg::CURR_BAND)) duty_lvl = duty_raise(duty_lvl);
    end

    r.duty     = duty_lvl;
    r.cur_mode = cur;
    r.limit    = 11'(lim >> 12);
    r.gain     = gain_lvl;
    return r;
  endfunction

  function automatic logic [11:0] sample_clip(int c);
    if (c < 0) return '0;
    if (c > 4095) return 12'hFFF;
    return 12'(c);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: a beat goes up at the falling edge and holds until taken
  // ---------------------------------------------------------------------------
  pass_in_t cur_pass;
  bit       beat_live = 1'b0;
  int       gap_left  = 0;

  always @(negedge clk_i) begin
    if (!beat_live) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0 &&
                   (!sample_q[0].hold || ctrl_result_q.size() == 0)) begin
        // a held pass only goes once every owed result has come back
        cur_pass        = sample_q.pop_front();
        beat_live       = 1'b1;
        volt_sample_i   <= cur_pass.volt;
        curr_sample_i   <= cur_pass.curr;
        photo_sample_i  <= cur_pass.photo;
        cell_sample_i   <= cur_pass.solar;
        light_reading_i <= cur_pass.reading;
        light_status_i  <= cur_pass.status;
        second_tick_i   <= cur_pass.tick;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // accepted beat: run the pass through the image and owe its result
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ctrl_result_q.push_back(regulate_pass(cur_pass));
      beat_live = 1'b0;
      gap_left  = src_idle ? int'($urandom_range(0, 6)) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: stall counts down only while a result is offered
  // ---------------------------------------------------------------------------
  int        stall_left = 0;
  ctrl_res_t due_res;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (!out_stall_i) begin
        if (ctrl_result_q.size() == 0) begin
          $error("result beat with none owed: pwm_duty %0d", pwm_duty_o);
          err_count++;
        end else begin
          due_res = ctrl_result_q.pop_front();
          if (pwm_duty_o !== due_res.duty) begin
            $error("pwm_duty: expected %0d, got %0d", due_res.duty, pwm_duty_o);
            err_count++;
          end
          if (current_mode_active_o !== due_res.cur_mode) begin
            $error("current_mode_active: expected %0d, got %0d",
                   due_res.cur_mode, current_mode_active_o);
            err_count++;
          end
          if (limit_ma_o !== due_res.limit) begin
            $error("limit_ma: expected %0d, got %0d", due_res.limit, limit_ma_o);
            err_count++;
          end
          if (gain_q12_o !== due_res.gain) begin
            $error("gain_q12: expected %0d, got %0d", due_res.gain, gain_q12_o);
            err_count++;
          end
          if (orbit_toggled_o !== due_res.toggled) begin
            $error("orbit_toggled: expected %0d, got %0d",
                   due_res.toggled, orbit_toggled_o);
            err_count++;
          end
        end
        stall_left = sink_idle ? int'($urandom_range(0, 6)) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (stall_left > 0);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cv_cc_pwm_step_regulator test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register port and sequencing helpers
  // ---------------------------------------------------------------------------
  // setup cycle, access cycle, then release
  task automatic apb_xfer(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // read back a register, compared over its own width
  task automatic reg_check(input logic [2:0] idx, input logic [31:0] want);
    logic [31:0] got, msk;
    case (idx)
      cvcc_pkg::REG_GAIN_MODE:   msk = 32'h7;
      cvcc_pkg::REG_VOLT_TARGET: msk = 32'h1FFF;
      cvcc_pkg::REG_CURR_TARGET: msk = 32'h7FF;
      cvcc_pkg::REG_DUTY_INC:    msk = 32'h3FF;
      default:                   msk = 32'hFFFF;
    endcase
    apb_xfer(idx, 1'b0, '0, got);
    if ((got & msk) != (want & msk)) begin
      $error("register %0d: expected %0d, got %0d", idx, want & msk, got & msk);
      err_count++;
    end
  endtask

  // nothing queued, nothing in flight, nothing owed
  task automatic wait_quiet();
    while (sample_q.size() != 0 || beat_live || ctrl_result_q.size() != 0)
      @(posedge clk_i);
  endtask

  // writes only land on an idle block; the image follows the same side effects
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    wait_quiet();
    apb_xfer(idx, 1'b1, val, unused);
    case (idx)
      cvcc_pkg::REG_GAIN_MODE: begin
        cfg_mode = val[2:0];
        // entering orbit or fixed mode restarts at gain one
        if (cfg_mode == cvcc_pkg::GM_ORBIT || cfg_mode == cvcc_pkg::GM_FIXED)
          gain_lvl = cvcc_pkg::GAIN_ONE;
        if (cfg_mode == cvcc_pkg::GM_ORBIT) orbit_cnt = '0;
      end
      cvcc_pkg::REG_VOLT_TARGET: cfg_volt_mv = val[12:0];
      cvcc_pkg::REG_CURR_TARGET: cfg_curr_ma = val[10:0];
      cvcc_pkg::REG_DUTY_INC:    cfg_step    = val[9:0];
      cvcc_pkg::REG_ORBIT_PER:   cfg_period  = val[15:0];
      default: ;
    endcase
    reg_check(idx, val);
  endtask

  task automatic queue_pass(input int v, input int c, input int ph, input int ce,
                            input int rd, input logic [1:0] st, input logic tk);
    pass_in_t p;
    p.volt    = 12'(v);
    p.curr    = 12'(c);
    p.photo   = 12'(ph);
    p.solar   = 12'(ce);
    p.reading = 16'(rd);
    p.status  = st;
    p.tick    = tk;
    p.hold    = 1'b0;
    sample_q.push_back(p);
  endtask

  // mostly near the deadbands so both loops actually regulate, with some raw noise
  task automatic queue_random_pass();
    pass_in_t p;
    int       c, sel;
    c = (int'(cfg_volt_mv) * 40960) / int'(cvcc_pkg::VOLT_COEF)
        + int'($urandom_range(0, 120)) - 60;
    p.volt = ($urandom_range(0, 9) < 7) ? sample_clip(c) : 12'($urandom);
    c = (int'(cfg_curr_ma) * int'($urandom_range(0, 4096))) / int'(cvcc_pkg::CURR_COEF)
        + int'($urandom_range(0, 200)) - 100;
    p.curr  = ($urandom_range(0, 9) < 6) ? sample_clip(c) : 12'($urandom);
    p.photo = 12'($urandom);
    p.solar = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 220)) : 12'($urandom);
    sel = int'($urandom_range(0, 7));
    case (sel)
      0:       p.reading = '0;
      1:       p.reading = 16'h8000 | 16'($urandom);
      2, 3, 4: p.reading = 16'($urandom_range(1, 400));
      5:       p.reading = 16'($urandom_range(1, 32767));
      default: p.reading = 16'($urandom);
    endcase
    sel = int'($urandom_range(0, 9));
    if (sel < 7) p.status = cvcc_pkg::LS_OK;
    else if (sel == 7) p.status = cvcc_pkg::LS_ADDR_FAIL;
    else if (sel == 8) p.status = LS_READ_FAIL;
    else p.status = LS_RESERVED;
    p.tick = 1'($urandom_range(0, 1));
    p.hold = ($urandom_range(0, 49) == 0);
    sample_q.push_back(p);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int         ph, n, sel;
    logic [2:0] m;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // register defaults straight out of reset
    reg_check(cvcc_pkg::REG_GAIN_MODE, 32'(cvcc_pkg::GM_PHOTO));
    reg_check(cvcc_pkg::REG_VOLT_TARGET, 32'd5500);
    reg_check(cvcc_pkg::REG_CURR_TARGET, 32'd250);
    reg_check(cvcc_pkg::REG_DUTY_INC, 32'd10);
    reg_check(cvcc_pkg::REG_ORBIT_PER, 32'd899);

    src_idle  = 1'b1;
    sink_idle = 1'b1;

    // photodiode gain at both ends of the sample range, all fields at extremes
    queue_pass(0, 0, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(4095, 4095, 4095, 4095, -1, LS_READ_FAIL, 1'b1);

    // full-scale duty step: floor at zero, sit at zero, then back to the top
    reg_write(cvcc_pkg::REG_DUTY_INC, 32'd1023);
    reg_write(cvcc_pkg::REG_GAIN_MODE, 32'(cvcc_pkg::GM_CELL));
    queue_pass(0, 0, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(0, 0, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(0, 0, 0, 205, 0, cvcc_pkg::LS_OK, 1'b1);
    queue_pass(4095, 0, 0, 4095, 0, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(4095, 0, 0, 1, 0, cvcc_pkg::LS_OK, 1'b0);

    // light sensor: zero, negative, tiny, around 191, largest, and every status
    // voltage setpoint zero puts the lower band edge below zero
    reg_write(cvcc_pkg::REG_DUTY_INC, 32'd1);
    reg_write(cvcc_pkg::REG_VOLT_TARGET, 32'd0);
    reg_write(cvcc_pkg::REG_CURR_TARGET, 32'd2047);
    reg_write(cvcc_pkg::REG_GAIN_MODE, 32'(cvcc_pkg::GM_SENSOR));
    queue_pass(0, 0, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(0, 0, 0, 0, -32768, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(40, 4095, 0, 0, 1, cvcc_pkg::LS_OK, 1'b1);
    queue_pass(40, 0, 0, 0, 191, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(12, 2000, 0, 0, 192, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(0, 4095, 0, 0, 32767, cvcc_pkg::LS_OK, 1'b1);
    queue_pass(0, 4095, 0, 0, 1, cvcc_pkg::LS_ADDR_FAIL, 1'b0);
    queue_pass(0, 0, 0, 0, 5, LS_READ_FAIL, 1'b0);
    queue_pass(0, 0, 0, 0, -5, LS_RESERVED, 1'b0);

    // orbit toggling, then a zero period that toggles every pass
    reg_write(cvcc_pkg::REG_VOLT_TARGET, 32'd7000);
    reg_write(cvcc_pkg::REG_ORBIT_PER, 32'd1);
    reg_write(cvcc_pkg::REG_GAIN_MODE, 32'(cvcc_pkg::GM_ORBIT));
    queue_pass(2500, 1000, 0, 0, 0, cvcc_pkg::LS_OK, 1'b1);
    queue_pass(2500, 1000, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);
    queue_pass(2500, 1000, 0, 0, 0, cvcc_pkg::LS_OK, 1'b1);
    reg_write(cvcc_pkg::REG_ORBIT_PER, 32'd0);
    queue_pass(2200, 0, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);

    // unused codes fall back to fixed gain, then fixed gain itself
    reg_write(cvcc_pkg::REG_GAIN_MODE, 32'(GM_SPARE_LO));
    queue_pass(1000, 2047, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);
    reg_write(cvcc_pkg::REG_GAIN_MODE, 32'(GM_SPARE_HI));
    queue_pass(1000, 100, 0, 0, 0, cvcc_pkg::LS_OK, 1'b0);
    reg_write(cvcc_pkg::REG_GAIN_MODE, 32'(cvcc_pkg::GM_FIXED));
    queue_pass(3000, 100, 0, 0, 0, cvcc_pkg::LS_OK, 1'b1);

    // random phases, each with its own register set and idling mix
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       m = cvcc_pkg::GM_FIXED;
        1:       m = cvcc_pkg::GM_PHOTO;
        2:       m = cvcc_pkg::GM_CELL;
        3:       m = cvcc_pkg::GM_SENSOR;
        4:       m = cvcc_pkg::GM_ORBIT;
        5:       m = cvcc_pkg::GM_SENSOR;
        6:       m = cvcc_pkg::GM_ORBIT;
        default: m = GM_SPARE_MID;
      endcase

      sel = int'($urandom_range(0, 7));
      case (sel)
        0:       reg_write(cvcc_pkg::REG_VOLT_TARGET, 32'd0);
        1:       reg_write(cvcc_pkg::REG_VOLT_TARGET, 32'd7000);
        2:       reg_write(cvcc_pkg::REG_VOLT_TARGET, 32'h1FFF);
        default: reg_write(cvcc_pkg::REG_VOLT_TARGET, 32'($urandom_range(0, 7000)));
      endcase
      sel = int'($urandom_range(0, 7));
      case (sel)
        0:       reg_write(cvcc_pkg::REG_CURR_TARGET, 32'd0);
        1:       reg_write(cvcc_pkg::REG_CURR_TARGET, 32'd2000);
        2:       reg_write(cvcc_pkg::REG_CURR_TARGET, 32'h7FF);
        default: reg_write(cvcc_pkg::REG_CURR_TARGET, 32'($urandom_range(0, 2000)));
      endcase
      sel = int'($urandom_range(0, 7));
      case (sel)
        0:       reg_write(cvcc_pkg::REG_DUTY_INC, 32'd1);
        1:       reg_write(cvcc_pkg::REG_DUTY_INC, 32'd1023);
        2:       reg_write(cvcc_pkg::REG_DUTY_INC, 32'd0);
        default: reg_write(cvcc_pkg::REG_DUTY_INC, 32'($urandom_range(1, 80)));
      endcase
      sel = int'($urandom_range(0, 7));
      case (sel)
        0:       reg_write(cvcc_pkg::REG_ORBIT_PER, 32'd1);
        1:       reg_write(cvcc_pkg::REG_ORBIT_PER, 32'd65535);
        2:       reg_write(cvcc_pkg::REG_ORBIT_PER, 32'd0);
        3:       reg_write(cvcc_pkg::REG_ORBIT_PER, 32'd899);
        default: reg_write(cvcc_pkg::REG_ORBIT_PER, 32'($urandom_range(1, 12)));
      endcase
      reg_write(cvcc_pkg::REG_GAIN_MODE, 32'(m));

      // none, source only, sink only, both
      src_idle  = (ph % 4 == 1) || (ph % 4 == 3);
      sink_idle = (ph % 4 == 2) || (ph % 4 == 3);

      for (n = 0; n < PHASE_PASSES; n++) queue_random_pass();
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("cv_cc_pwm_step_regulator test passed");
    end else begin
      $display("cv_cc_pwm_step_regulator test failed");
    end
    $finish;
  end

endmodule
